/* hdl/nvrp_pkg.sv */
`default_nettype none

package nvrp_pkg;

    // Fixed-point formats
    localparam int ID_BITS         = 16;
    localparam int COORD_FRAC_BITS = 16;
    localparam int DIR_FRAC_BITS   = 14;

    // Port field widths
    localparam int COORD_W    = 32;
    localparam int DIR_W      = 16;
    localparam int CUBE_ID_W  = 16;
    localparam int DIST_W     = 47;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Stored id bits: the low ID_BITS bits of cube_id, never more than the field
    localparam int ID_W = (ID_BITS < CUBE_ID_W) ? ID_BITS : CUBE_ID_W;

    // Datapath widths
    localparam int DIFF_W = COORD_W + 1;      // center - origin
    localparam int EDGE_W = COORD_W + 2;      // center - origin - half
    localparam int SDIR_W = DIR_W + 1;        // direction after sign fold
    localparam int PROD_W = EDGE_W + SDIR_W;  // plane cross products
    localparam int SPAN_W = PROD_W + 1;       // far edge of a plane product
    localparam int TERM_W = DIFF_W + DIR_W;   // one dot product term
    localparam int DOT_W  = TERM_W + 2;       // sum of three terms

    localparam logic signed [EDGE_W-1:0] HALF_UNIT =
        EDGE_W'(64'sd1 <<< (COORD_FRAC_BITS - 1));
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    // Register reset values
    localparam logic signed [COORD_W-1:0] ORIGIN_X_RST = '0;
    localparam logic signed [COORD_W-1:0] ORIGIN_Y_RST = COORD_W'(10 << COORD_FRAC_BITS);
    localparam logic signed [COORD_W-1:0] ORIGIN_Z_RST = COORD_W'(10 << COORD_FRAC_BITS);
    localparam logic signed [DIR_W-1:0]   DIR_X_RST    = '0;
    localparam logic signed [DIR_W-1:0]   DIR_Y_RST    = '0;
    localparam logic signed [DIR_W-1:0]   DIR_Z_RST    = DIR_W'(-(1 << DIR_FRAC_BITS));

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_X    = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y    = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Z    = CFG_IDX_W'(5);

    // Axis numbering and the (a, b) axes of the XY, YZ and XZ planes
    localparam int AXES   = 3;
    localparam int PLANES = 3;
    typedef logic [1:0] axis_t;
    localparam axis_t PLANE_A [PLANES] = '{2'd0, 2'd1, 2'd0};
    localparam axis_t PLANE_B [PLANES] = '{2'd1, 2'd2, 2'd2};

    // Queue between front and back end; depth is a power of two
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One classified cube
    typedef struct packed {
        logic              last;
        logic              hit;
        logic [DIST_W-1:0] distance;
        logic [ID_W-1:0]   id;
    } nvrp_item_t;

    // Queue status toward both ends
    typedef struct packed {
        logic full;
        logic valid;
    } nvrp_qstat_t;

endpackage

`default_nettype wire

/* hdl/nearest_voxel_ray_pick.sv */
`default_nettype none

// Channel   Direction  Handshake          Payload
// cfg       in         cfg_we             cfg_idx, cfg_wdata (origin_x..dir_z)
// s         in         s_valid/s_ready    center_x/y/z, cube_id, scan_end
// m         out        m_valid/m_ready    hit_found, hit_cube_id, hit_distance
//
// One cube transaction per cycle while s_ready is high; a scan-end transaction
// posts its result through three front stages, the queue and the result reg.
// Products sit in front stage 2; the back end registers the best-hit update.
// aresetn is synchronous, active low; it restores the default ray and clears
// the best hit, the queue and both valid paths.
// A stalled m side stops scan-end pops, backing up the 4-entry queue, the front
// stages and s_ready; a full queue holds the front even if the back end pops.

module nearest_voxel_ray_pick (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // configuration writes
    input  logic                                  cfg_we,
    input  logic [nvrp_pkg::CFG_IDX_W-1:0]        cfg_idx,
    input  logic [nvrp_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    // cube stream
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [nvrp_pkg::COORD_W-1:0]   s_center_x,
    input  logic signed [nvrp_pkg::COORD_W-1:0]   s_center_y,
    input  logic signed [nvrp_pkg::COORD_W-1:0]   s_center_z,
    input  logic [nvrp_pkg::CUBE_ID_W-1:0]        s_cube_id,
    input  logic                                  s_scan_end,
    // pick result
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_hit_found,
    output logic [nvrp_pkg::CUBE_ID_W-1:0]        m_hit_cube_id,
    output logic [nvrp_pkg::DIST_W-1:0]           m_hit_distance
);
    import nvrp_pkg::*;

    // Front end -> queue: classified cubes (scan-end flag, hit flag, saturated distance, id)
    logic        q_push;
    nvrp_item_t  q_in_item;
    // Queue -> back end
    logic        q_pop;
    nvrp_item_t  q_head;
    nvrp_qstat_t q_stat;

    // Front end: holds the ray, computes the dot distance and the three
    // plane crossing tests by cross-multiplication, no division.
    nvrp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_idx    (cfg_idx),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_center_x (s_center_x),
        .s_center_y (s_center_y),
        .s_center_z (s_center_z),
        .s_cube_id  (s_cube_id),
        .s_scan_end (s_scan_end),
        .q_stat     (q_stat),
        .q_push     (q_push),
        .q_item     (q_in_item)
    );

    // Short queue so front and back stall independently
    nvrp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_in_item),
        .pop       (q_pop),
        .head_item (q_head),
        .stat      (q_stat)
    );

    // Back end: nearest-hit tracking and the result register
    nvrp_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_item         (q_head),
        .q_stat         (q_stat),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_hit_found    (m_hit_found),
        .m_hit_cube_id  (m_hit_cube_id),
        .m_hit_distance (m_hit_distance)
    );

endmodule

`default_nettype wire

/* hdl/nvrp_front.sv */
`default_nettype none

module nvrp_front (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_we,
    input  logic [nvrp_pkg::CFG_IDX_W-1:0]         cfg_idx,
    input  logic [nvrp_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [nvrp_pkg::COORD_W-1:0]    s_center_x,
    input  logic signed [nvrp_pkg::COORD_W-1:0]    s_center_y,
    input  logic signed [nvrp_pkg::COORD_W-1:0]    s_center_z,
    input  logic [nvrp_pkg::CUBE_ID_W-1:0]         s_cube_id,
    input  logic                                   s_scan_end,
    input  nvrp_pkg::nvrp_qstat_t                  q_stat,
    output logic                                   q_push,
    output nvrp_pkg::nvrp_item_t                   q_item
);
    import nvrp_pkg::*;

    // Ray registers
    logic signed [COORD_W-1:0] org_x_reg, org_y_reg, org_z_reg;
    logic signed [DIR_W-1:0]   dir_x_reg, dir_y_reg, dir_z_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            org_x_reg <= ORIGIN_X_RST;
            org_y_reg <= ORIGIN_Y_RST;
            org_z_reg <= ORIGIN_Z_RST;
            dir_x_reg <= DIR_X_RST;
            dir_y_reg <= DIR_Y_RST;
            dir_z_reg <= DIR_Z_RST;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                CFG_ORIGIN_X: org_x_reg <= cfg_wdata[COORD_W-1:0];
                CFG_ORIGIN_Y: org_y_reg <= cfg_wdata[COORD_W-1:0];
                CFG_ORIGIN_Z: org_z_reg <= cfg_wdata[COORD_W-1:0];
                CFG_DIR_X:    dir_x_reg <= cfg_wdata[DIR_W-1:0];
                CFG_DIR_Y:    dir_y_reg <= cfg_wdata[DIR_W-1:0];
                CFG_DIR_Z:    dir_z_reg <= cfg_wdata[DIR_W-1:0];
                default: ;
            endcase
        end
    end

    logic signed [COORD_W-1:0] org_v [AXES];
    logic signed [COORD_W-1:0] cen_v [AXES];
    logic signed [DIR_W-1:0]   dir_v [AXES];

    assign org_v[0] = org_x_reg;
    assign org_v[1] = org_y_reg;
    assign org_v[2] = org_z_reg;
    assign cen_v[0] = s_center_x;
    assign cen_v[1] = s_center_y;
    assign cen_v[2] = s_center_z;
    assign dir_v[0] = dir_x_reg;
    assign dir_v[1] = dir_y_reg;
    assign dir_v[2] = dir_z_reg;

    // Per plane: |da| and db with the sign of da folded in
    logic signed [SDIR_W-1:0] da_abs [PLANES];
    logic signed [SDIR_W-1:0] db_adj [PLANES];
    logic                     da_zero [PLANES];

    always_comb begin
        for (int p = 0; p < PLANES; p++) begin
            da_zero[p] = (dir_v[PLANE_A[p]] == '0);
            if (dir_v[PLANE_A[p]] < 0) begin
                da_abs[p] = -SDIR_W'(dir_v[PLANE_A[p]]);
                db_adj[p] = -SDIR_W'(dir_v[PLANE_B[p]]);
            end else begin
                da_abs[p] = SDIR_W'(dir_v[PLANE_A[p]]);
                db_adj[p] = SDIR_W'(dir_v[PLANE_B[p]]);
            end
        end
    end

    // Pipeline control: every stage moves unless the last one is blocked
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic advance;

    assign advance = !s3_valid_reg || !q_stat.full;
    assign s_ready = advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= s_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // Stage 1: offsets from the ray origin
    logic signed [DIFF_W-1:0] s1_e_reg  [AXES];
    logic signed [EDGE_W-1:0] s1_el_reg [AXES];
    logic [ID_W-1:0]          s1_id_reg;
    logic                     s1_last_reg;

    // Stage 2: products
    logic signed [TERM_W-1:0] s2_term_reg [AXES];
    logic signed [PROD_W-1:0] s2_n0_reg   [PLANES];
    logic signed [PROD_W-1:0] s2_lo_reg   [PLANES];
    logic                     s2_open_reg [PLANES];
    logic [ID_W-1:0]          s2_id_reg;
    logic                     s2_last_reg;

    // Stage 3: dot sum and far edges
    logic signed [DOT_W-1:0]  s3_dot_reg;
    logic signed [SPAN_W-1:0] s3_n0_reg   [PLANES];
    logic signed [SPAN_W-1:0] s3_n1_reg   [PLANES];
    logic signed [SPAN_W-1:0] s3_lo_reg   [PLANES];
    logic signed [SPAN_W-1:0] s3_hi_reg   [PLANES];
    logic                     s3_open_reg [PLANES];
    logic [ID_W-1:0]          s3_id_reg;
    logic                     s3_last_reg;

    // Open interval test on the a axis: |center - origin| < half
    logic axis_open [AXES];

    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            axis_open[i] = (EDGE_W'(s1_e_reg[i]) > -HALF_UNIT) &&
                           (EDGE_W'(s1_e_reg[i]) < HALF_UNIT);
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int i = 0; i < AXES; i++) begin
                s1_e_reg[i]  <= DIFF_W'(cen_v[i]) - DIFF_W'(org_v[i]);
                s1_el_reg[i] <= EDGE_W'(cen_v[i]) - EDGE_W'(org_v[i]) - HALF_UNIT;
            end
            s1_id_reg   <= s_cube_id[ID_W-1:0];
            s1_last_reg <= s_scan_end;

            for (int i = 0; i < AXES; i++) begin
                s2_term_reg[i] <= TERM_W'(s1_e_reg[i]) * TERM_W'(dir_v[i]);
            end
            for (int p = 0; p < PLANES; p++) begin
                s2_n0_reg[p]   <= PROD_W'(db_adj[p]) * PROD_W'(s1_el_reg[PLANE_A[p]]);
                s2_lo_reg[p]   <= PROD_W'(s1_el_reg[PLANE_B[p]]) * PROD_W'(da_abs[p]);
                s2_open_reg[p] <= axis_open[PLANE_A[p]];
            end
            s2_id_reg   <= s1_id_reg;
            s2_last_reg <= s1_last_reg;

            s3_dot_reg <= DOT_W'(s2_term_reg[0]) + DOT_W'(s2_term_reg[1]) +
                          DOT_W'(s2_term_reg[2]);
            for (int p = 0; p < PLANES; p++) begin
                // square is one unit wide: the far edge adds direction << frac
                s3_n0_reg[p]   <= SPAN_W'(s2_n0_reg[p]);
                s3_n1_reg[p]   <= SPAN_W'(s2_n0_reg[p]) +
                                  (SPAN_W'(db_adj[p]) <<< COORD_FRAC_BITS);
                s3_lo_reg[p]   <= SPAN_W'(s2_lo_reg[p]);
                s3_hi_reg[p]   <= SPAN_W'(s2_lo_reg[p]) +
                                  (SPAN_W'(da_abs[p]) <<< COORD_FRAC_BITS);
                s3_open_reg[p] <= s2_open_reg[p];
            end
            s3_id_reg   <= s2_id_reg;
            s3_last_reg <= s2_last_reg;
        end
    end

    // Stage 4 logic: crossing decision per plane, saturation, push
    logic signed [SPAN_W-1:0] pmin [PLANES];
    logic signed [SPAN_W-1:0] pmax [PLANES];
    logic                     plane_hit [PLANES];
    logic                     all_hit;

    always_comb begin
        for (int p = 0; p < PLANES; p++) begin
            if (s3_n0_reg[p] > s3_n1_reg[p]) begin
                pmin[p] = s3_n1_reg[p];
                pmax[p] = s3_n0_reg[p];
            end else begin
                pmin[p] = s3_n0_reg[p];
                pmax[p] = s3_n1_reg[p];
            end
            if (da_zero[p]) begin
                plane_hit[p] = s3_open_reg[p];
            end else if (pmin[p] < s3_lo_reg[p]) begin
                plane_hit[p] = pmax[p] > s3_lo_reg[p];
            end else begin
                plane_hit[p] = pmin[p] < s3_hi_reg[p];
            end
        end
        all_hit = plane_hit[0] && plane_hit[1] && plane_hit[2];
    end

    assign q_push          = s3_valid_reg && !q_stat.full;
    assign q_item.last     = s3_last_reg;
    assign q_item.hit      = !s3_dot_reg[DOT_W-1] && all_hit;
    assign q_item.distance = (|s3_dot_reg[DOT_W-1:DIST_W]) ? DIST_MAX
                                                            : s3_dot_reg[DIST_W-1:0];
    assign q_item.id       = s3_id_reg;

`ifndef ASSERT_OFF
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> s1_valid_reg)
        else $error("accepted transaction did not enter stage 1");

    a_blocked_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (s3_valid_reg && q_stat.full) |=> (s3_valid_reg && $stable(s3_id_reg)))
        else $error("blocked stage 3 lost its item");
`endif

endmodule

`default_nettype wire

/* hdl/nvrp_queue.sv */
`default_nettype none

module nvrp_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  nvrp_pkg::nvrp_item_t  push_item,
    input  logic                  pop,
    output nvrp_pkg::nvrp_item_t  head_item,
    output nvrp_pkg::nvrp_qstat_t stat
);
    import nvrp_pkg::*;

    nvrp_item_t        slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head_item  = slot_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.valid = (count_reg != '0);

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !stat.full)
        else $error("queue write while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> stat.valid)
        else $error("queue read while empty");
`endif

endmodule

`default_nettype wire

/* hdl/nvrp_back.sv */
`default_nettype none

module nvrp_back (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  nvrp_pkg::nvrp_item_t             q_item,
    input  nvrp_pkg::nvrp_qstat_t            q_stat,
    output logic                             q_pop,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_hit_found,
    output logic [nvrp_pkg::CUBE_ID_W-1:0]   m_hit_cube_id,
    output logic [nvrp_pkg::DIST_W-1:0]      m_hit_distance
);
    import nvrp_pkg::*;

    logic              best_valid_reg;
    logic [DIST_W-1:0] best_dist_reg;
    logic [ID_W-1:0]   best_id_reg;

    logic              m_valid_reg;
    logic              m_found_reg;
    logic [CUBE_ID_W-1:0] m_id_reg;
    logic [DIST_W-1:0]    m_dist_reg;

    logic              take;
    logic              best_valid_next;
    logic [DIST_W-1:0] best_dist_next;
    logic [ID_W-1:0]   best_id_next;
    logic              emit;

    // A scan-end item needs the result register free or draining this cycle
    assign q_pop = q_stat.valid && (!q_item.last || !m_valid_reg || m_ready);
    assign emit  = q_pop && q_item.last;

    // Strictly smaller wins, so the first of equal distances stays
    assign take            = q_item.hit &&
                             (!best_valid_reg || q_item.distance < best_dist_reg);
    assign best_valid_next = best_valid_reg || take;
    assign best_dist_next  = take ? q_item.distance : best_dist_reg;
    assign best_id_next    = take ? q_item.id       : best_id_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (q_pop) begin
                best_valid_reg <= emit ? 1'b0 : best_valid_next;
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            best_dist_reg <= best_dist_next;
            best_id_reg   <= best_id_next;
        end
        if (emit) begin
            m_found_reg <= best_valid_next;
            m_id_reg    <= best_valid_next ? CUBE_ID_W'(best_id_next) : '0;
            m_dist_reg  <= best_valid_next ? best_dist_next : '0;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_hit_found    = m_found_reg;
    assign m_hit_cube_id  = m_id_reg;
    assign m_hit_distance = m_dist_reg;

`ifndef ASSERT_OFF
    a_emit_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> (m_valid_reg && !best_valid_reg))
        else $error("scan end did not post a result and clear the best hit");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !emit)
        else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire
